>>> src/pt100_resistance_to_temperature_defines.svh
// ---------------------------------------------------------------------------
// PT100 converter assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef PT100_RESISTANCE_TO_TEMPERATURE_DEFINES_SVH
`define PT100_RESISTANCE_TO_TEMPERATURE_DEFINES_SVH
`ifndef SYNTHESIS
`define PRT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("prt assertion failed");
`define PRT_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("prt assertion failed");
`else
`define PRT_ASSERT(label, clk, rst_n, prop)
`define PRT_ASSERT_NR(label, clk, prop)
`endif
`endif

>>> src/prt_pkg.sv
// ---------------------------------------------------------------------------
// PT100 converter package
// Resistance table, widths, status codes and controller/datapath structs.
// ---------------------------------------------------------------------------
package prt_pkg;

    localparam int unsigned OHMS_W   = 16;
    localparam int unsigned TEMP_W   = 18;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned IDX_W    = 7;   // holds 0..96
    localparam int unsigned SEG_W    = 9;   // widest table step is 404
    localparam int unsigned QUO_W    = 10;  // fraction 0..1000
    localparam int unsigned REM_W    = 19;  // 404 * 1000 < 2**19
    localparam int unsigned CNT_W    = 4;
    localparam int unsigned OFFS_W   = 17;  // 94 * 1000 < 2**17

    localparam logic [IDX_W-1:0]  TABLE_LEN  = 7'd96;
    localparam logic [CNT_W-1:0]  DIV_STEPS  = 4'd10;
    localparam logic [REM_W-1:0]  STEP_CENTI = 19'd1000;
    localparam logic signed [TEMP_W-1:0] BASE_CENTI = -18'sd10000;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OPEN  = 2'd2;

    // resistance x100 at every 10 C from -100 C
    localparam logic [OHMS_W-1:0] RTD_TABLE [0:95] = '{
        16'd6026,  16'd6430,  16'd6833,  16'd7233,  16'd7633,  16'd8031,
        16'd8427,  16'd8822,  16'd9216,  16'd9609,  16'd10000, 16'd10390,
        16'd10779, 16'd11167, 16'd11554, 16'd11940, 16'd12324, 16'd12708,
        16'd13090, 16'd13471, 16'd13851, 16'd14229, 16'd14607, 16'd14983,
        16'd15358, 16'd15733, 16'd16105, 16'd16477, 16'd16848, 16'd17217,
        16'd17586, 16'd17953, 16'd18319, 16'd18684, 16'd19047, 16'd19410,
        16'd19771, 16'd20131, 16'd20490, 16'd20848, 16'd21205, 16'd21561,
        16'd21915, 16'd22268, 16'd22621, 16'd22972, 16'd23321, 16'd23670,
        16'd24018, 16'd24364, 16'd24709, 16'd25053, 16'd25396, 16'd25738,
        16'd26078, 16'd26418, 16'd26756, 16'd27093, 16'd27429, 16'd27764,
        16'd28098, 16'd28430, 16'd28762, 16'd29092, 16'd29421, 16'd29749,
        16'd30075, 16'd30401, 16'd30725, 16'd31048, 16'd31371, 16'd31692,
        16'd32012, 16'd32330, 16'd32648, 16'd32964, 16'd33279, 16'd33593,
        16'd33906, 16'd34218, 16'd34528, 16'd34838, 16'd35146, 16'd35453,
        16'd35759, 16'd36064, 16'd36367, 16'd36670, 16'd36971, 16'd37271,
        16'd37570, 16'd37868, 16'd38165, 16'd38460, 16'd38755, 16'd39048
    };

    function automatic logic [OHMS_W-1:0] f_rtd(input logic [IDX_W-1:0] idx);
        logic [OHMS_W-1:0] v;
        v = '1;
        if (idx < TABLE_LEN) begin
            v = RTD_TABLE[idx];
        end
        return v;
    endfunction

    typedef struct packed {
        logic load;
        logic search_step;
        logic prep;
        logic mult;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic search_done;
        logic in_range;
        logic div_last;
    } t_sts;

endpackage

>>> src/pt100_resistance_to_temperature.sv
// An input transaction loads the reading and starts a binary search; in-range
//   readings then go through segment fetch, scaling and 10 divide steps.
// A new reading is accepted only once the sequencer is back in idle, after
//   the previous result has been loaded into the output register.
// A finished result waits in the output register while the next reading runs.
// Reset (synchronous, active low) returns the sequencer to idle and drops
//   o_valid; no table or memory needs clearing.
// ---------------------------------------------------------------------------
// PT100 resistance to temperature converter
// Table search over 96 calibration points, then linear interpolation in
// hundredths of a degree with the fraction truncated.
// ---------------------------------------------------------------------------
module pt100_resistance_to_temperature (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [prt_pkg::OHMS_W-1:0]          i_ohms_x100,
    // output channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [prt_pkg::TEMP_W-1:0]   o_temperature_centi,
    output logic [prt_pkg::STATUS_W-1:0]        o_status
);

    // command and status between sequencer and datapath
    prt_pkg::t_cmd w_cmd;
    prt_pkg::t_sts w_sts;

    // Sequencer: idle -> binary search (one halving per cycle) -> segment
    // fetch -> scale by 1000 -> ten restoring divide steps -> load result.
    // Readings outside the table skip straight from fetch to the result.
    prt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Datapath: search bounds, segment numerator/denominator, divider and
    // the output register that holds a result until its transaction.
    prt_dp u_dp (
        .i_clk               (i_clk),
        .i_ohms_x100         (i_ohms_x100),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .o_temperature_centi (o_temperature_centi),
        .o_status            (o_status)
    );

endmodule

>>> src/prt_dp.sv
// ---------------------------------------------------------------------------
// PT100 converter datapath
// Binary search bounds, segment fetch, scaling and restoring divider.
// ---------------------------------------------------------------------------
module prt_dp (
    input  logic                                i_clk,
    input  logic [prt_pkg::OHMS_W-1:0]          i_ohms_x100,
    input  prt_pkg::t_cmd                       i_cmd,
    output prt_pkg::t_sts                       o_sts,
    output logic signed [prt_pkg::TEMP_W-1:0]   o_temperature_centi,
    output logic [prt_pkg::STATUS_W-1:0]        o_status
);

    logic [prt_pkg::OHMS_W-1:0]        r_ohms;
    logic [prt_pkg::IDX_W-1:0]         r_lo, r_hi;
    logic [prt_pkg::SEG_W-1:0]         r_num, r_den;
    logic [prt_pkg::REM_W-1:0]         r_rem, r_dvs;
    logic [prt_pkg::QUO_W-1:0]         r_quo;
    logic [prt_pkg::CNT_W-1:0]         r_cnt;
    logic signed [prt_pkg::TEMP_W-1:0] r_temp;
    logic [prt_pkg::STATUS_W-1:0]      r_status;

    logic [prt_pkg::IDX_W:0]           w_sum;
    logic [prt_pkg::IDX_W-1:0]         w_mid;
    logic [prt_pkg::IDX_W-1:0]         w_seg;
    logic [prt_pkg::OHMS_W-1:0]        w_below, w_above;
    logic [prt_pkg::OFFS_W-1:0]        w_offs;
    logic signed [prt_pkg::TEMP_W-1:0] w_temp;
    logic                              w_fits;

    assign w_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid   = w_sum[prt_pkg::IDX_W:1];
    assign w_seg   = r_lo - 7'd1;
    assign w_below = prt_pkg::f_rtd(w_seg);
    assign w_above = prt_pkg::f_rtd(r_lo);
    assign w_fits  = (r_rem >= r_dvs);
    assign w_offs  = prt_pkg::OFFS_W'(w_seg) * prt_pkg::OFFS_W'(prt_pkg::STEP_CENTI);
    assign w_temp  = prt_pkg::BASE_CENTI
                   + $signed({1'b0, w_offs})
                   + $signed({{(prt_pkg::TEMP_W-prt_pkg::QUO_W){1'b0}}, r_quo});

    assign o_sts.search_done = (r_lo == r_hi);
    assign o_sts.in_range    = (r_lo != '0) && (r_lo != prt_pkg::TABLE_LEN);
    assign o_sts.div_last    = (r_cnt == 4'd1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ohms <= i_ohms_x100;
            r_lo   <= '0;
            r_hi   <= prt_pkg::TABLE_LEN;
        end
        if (i_cmd.search_step) begin
            if (r_ohms <= prt_pkg::f_rtd(w_mid)) begin
                r_hi <= w_mid;
            end else begin
                r_lo <= w_mid + 7'd1;
            end
        end
        if (i_cmd.prep) begin
            r_num <= prt_pkg::SEG_W'(r_ohms - w_below);
            r_den <= prt_pkg::SEG_W'(w_above - w_below);
        end
        if (i_cmd.mult) begin
            r_rem <= prt_pkg::REM_W'(r_num) * prt_pkg::STEP_CENTI;
            r_dvs <= {r_den, {(prt_pkg::QUO_W-1){1'b0}}, 1'b0} >> 1;
            r_quo <= '0;
            r_cnt <= prt_pkg::DIV_STEPS;
        end
        if (i_cmd.div_step) begin
            if (w_fits) begin
                r_rem <= r_rem - r_dvs;
            end
            r_quo <= {r_quo[prt_pkg::QUO_W-2:0], w_fits};
            r_dvs <= r_dvs >> 1;
            r_cnt <= r_cnt - 4'd1;
        end
        if (i_cmd.finish) begin
            if (r_lo == '0) begin
                r_status <= prt_pkg::ST_SHORT;
                r_temp   <= '0;
            end else if (r_lo == prt_pkg::TABLE_LEN) begin
                r_status <= prt_pkg::ST_OPEN;
                r_temp   <= '0;
            end else begin
                r_status <= prt_pkg::ST_OK;
                r_temp   <= w_temp;
            end
        end
    end

    assign o_temperature_centi = r_temp;
    assign o_status            = r_status;

endmodule

>>> src/prt_ctrl.sv
// ---------------------------------------------------------------------------
// PT100 converter controller
// Sequences search, scaling and division; owns both handshakes.
// ---------------------------------------------------------------------------
`include "pt100_resistance_to_temperature_defines.svh"

module prt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  prt_pkg::t_sts i_sts,
    output prt_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_PREP,
        S_MULT,
        S_DIV,
        S_FINISH
    } t_state;

    t_state        r_state, n_state;
    logic          r_ready, n_ready;
    logic          r_out_valid, n_out_valid;
    logic          w_out_free;
    prt_pkg::t_cmd w_cmd;

    assign w_out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_ready;
        w_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid && r_ready) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_sts.search_done) begin
                    n_state = S_PREP;
                end else begin
                    w_cmd.search_step = 1'b1;
                end
            end
            S_PREP: begin
                w_cmd.prep = 1'b1;
                n_state    = i_sts.in_range ? S_MULT : S_FINISH;
            end
            S_MULT: begin
                w_cmd.mult = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                w_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    w_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ready     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ready     <= n_ready;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = r_ready;
    assign o_valid = r_out_valid;
    assign o_cmd   = w_cmd;

    `PRT_ASSERT(a_accept_starts_search, i_clk, i_rst_n, (i_valid && o_ready) |=> (r_state == S_SEARCH))
    `PRT_ASSERT(a_finish_waits, i_clk, i_rst_n, (r_state == S_FINISH && o_valid && !i_ready) |=> (r_state == S_FINISH && o_valid))
    `PRT_ASSERT(a_single_cmd, i_clk, i_rst_n, $onehot0(w_cmd))
    `PRT_ASSERT_NR(a_reset_state, i_clk, !i_rst_n |=> (!o_valid && o_ready))

endmodule
